FILE: hw/rtl/icmp_echo_reply_parser_assert.svh
// Assertion helpers shared by the parser modules.
`ifndef ICMP_ECHO_REPLY_PARSER_ASSERT_SVH
`define ICMP_ECHO_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICMP_ERP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ICMP_ERP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/icmp_erp_pkg.sv
package icmp_erp_pkg;

  localparam int MAX_PACKET_BYTES  = 2048;
  localparam int MICROS_PER_SECOND = 1000000;
  localparam int ICMP_MIN_BYTES    = 8;
  localparam int REPLY_MIN_BYTES   = 16;
  localparam int APB_ADDR_W        = 3;

  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

  typedef enum logic [2:0] {
    ST_REPLY_OK    = 3'd0,
    ST_NOT_ICMP    = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_WRONG_ID    = 3'd3,
    ST_REPLY_SHORT = 3'd4,
    ST_OTHER_TYPE  = 3'd5,
    ST_IGNORED     = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    REG_OWN_IDENTIFIER = 1'b0,
    REG_REPORT_OTHER   = 1'b1
  } reg_idx_e;

  // Everything the classifier needs from one finished packet.
  typedef struct packed {
    logic [11:0] icmp_length;
    logic        len_short;
    logic        reply_short;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] identifier;
    logic [15:0] seq_num;
    logic [31:0] sent_seconds;
    logic [31:0] sent_micros;
    logic [31:0] rcv_seconds;
    logic [19:0] rcv_micros;
  } pkt_snap_t;

endpackage

FILE: hw/rtl/icmp_erp_if.sv
interface icmp_erp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] receive_seconds;
  logic [19:0] receive_micros;

  modport source (output valid, data_byte, last_byte, receive_seconds, receive_micros,
                  input ready);
  modport sink   (input valid, data_byte, last_byte, receive_seconds, receive_micros,
                  output ready);
endinterface

interface icmp_erp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [11:0]        icmp_length;
  logic [15:0]        sequence_number;
  logic [7:0]         time_to_live;
  logic [7:0]         message_type;
  logic [7:0]         message_code;
  logic [15:0]        seen_identifier;
  logic signed [31:0] trip_seconds;
  logic [19:0]        trip_micros;

  modport source (output valid, status, icmp_length, sequence_number, time_to_live,
                  message_type, message_code, seen_identifier, trip_seconds, trip_micros,
                  input ready);
  modport sink   (input valid, status, icmp_length, sequence_number, time_to_live,
                  message_type, message_code, seen_identifier, trip_seconds, trip_micros,
                  output ready);
endinterface

FILE: hw/rtl/icmp_erp_capture.sv
`include "icmp_echo_reply_parser_assert.svh"

module icmp_erp_capture #(
  parameter int MaxPacketBytes = icmp_erp_pkg::MAX_PACKET_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  icmp_erp_in_if.sink            pkt_i,
  input  logic                   snap_ready_i,
  output logic                   snap_valid_o,
  output icmp_erp_pkg::pkt_snap_t snap_o
);

  localparam int PosW = $clog2(MaxPacketBytes + 1);
  localparam int CmpW = (PosW > 12) ? PosW : 12;

  logic [PosW-1:0] pos_q, pos_d, cap_pos;
  logic [5:0]      hdr_q, hdr_d, cap_hdr, hl_cur;
  logic [7:0]      proto_q, proto_d, cap_proto;
  logic [7:0]      ttl_q, ttl_d, cap_ttl;
  logic [7:0]      type_q, type_d, cap_type;
  logic [7:0]      code_q, code_d, cap_code;
  logic [15:0]     id_q, id_d, cap_id;
  logic [15:0]     seq_q, seq_d, cap_seq;
  logic [31:0]     ssec_q, ssec_d, cap_ssec;
  logic [31:0]     sus_q, sus_d, cap_sus;

  logic            accept, last, cap_en, at_zero, in_icmp, k_small;
  logic [CmpW-1:0] k, tot_ext, hdr_ext, icmp_full, icmp_len;
  logic [3:0]      k_lo;
  logic            hdr_over;

  logic                    snap_valid_q;
  icmp_erp_pkg::pkt_snap_t snap_q, snap_d;

  assign accept       = pkt_i.valid & pkt_i.ready;
  assign last         = pkt_i.last_byte;
  assign pkt_i.ready  = ~snap_valid_q | snap_ready_i;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  // Offset of the current byte inside the ICMP part; the first byte may
  // set the header length and be an ICMP byte at once.
  assign cap_en  = pos_q < PosW'(MaxPacketBytes);
  assign at_zero = pos_q == '0;
  assign hl_cur  = at_zero ? {pkt_i.data_byte[3:0], 2'b00} : hdr_q;
  assign in_icmp = CmpW'(pos_q) >= CmpW'(hl_cur);
  assign k       = CmpW'(pos_q) - CmpW'(hl_cur);
  assign k_small = k < CmpW'(16);
  assign k_lo    = k[3:0];

  always_comb begin
    cap_pos   = pos_q;
    cap_hdr   = hdr_q;
    cap_proto = proto_q;
    cap_ttl   = ttl_q;
    cap_type  = type_q;
    cap_code  = code_q;
    cap_id    = id_q;
    cap_seq   = seq_q;
    cap_ssec  = ssec_q;
    cap_sus   = sus_q;
    if (cap_en) begin
      cap_pos = pos_q + PosW'(1);
      if (at_zero) begin
        cap_hdr = hl_cur;
      end
      if (pos_q == PosW'(8)) begin
        cap_ttl = pkt_i.data_byte;
      end
      if (pos_q == PosW'(9)) begin
        cap_proto = pkt_i.data_byte;
      end
      if (in_icmp && k_small) begin
        case (k_lo)
          4'd0: cap_type = pkt_i.data_byte;
          4'd1: cap_code = pkt_i.data_byte;
          4'd4, 4'd5: cap_id[{k_lo[0], 3'b000} +: 8] = pkt_i.data_byte;
          4'd6, 4'd7: cap_seq[{k_lo[0], 3'b000} +: 8] = pkt_i.data_byte;
          4'd8, 4'd9, 4'd10, 4'd11: cap_ssec[{k_lo[1:0], 3'b000} +: 8] = pkt_i.data_byte;
          4'd12, 4'd13, 4'd14, 4'd15: cap_sus[{k_lo[1:0], 3'b000} +: 8] = pkt_i.data_byte;
          default: ;
        endcase
      end
    end
  end

  // Length checks on the packet as it stands after this byte.
  assign tot_ext   = CmpW'(cap_pos);
  assign hdr_ext   = CmpW'(cap_hdr);
  assign hdr_over  = tot_ext < hdr_ext;
  assign icmp_full = tot_ext - hdr_ext;
  assign icmp_len  = hdr_over ? '0 : icmp_full;

  always_comb begin
    snap_d.icmp_length  = icmp_len[11:0];
    snap_d.len_short    = hdr_over | (icmp_len < CmpW'(icmp_erp_pkg::ICMP_MIN_BYTES));
    snap_d.reply_short  = icmp_len < CmpW'(icmp_erp_pkg::REPLY_MIN_BYTES);
    snap_d.protocol     = cap_proto;
    snap_d.ttl          = cap_ttl;
    snap_d.msg_type     = cap_type;
    snap_d.msg_code     = cap_code;
    snap_d.identifier   = cap_id;
    snap_d.seq_num      = cap_seq;
    snap_d.sent_seconds = cap_ssec;
    snap_d.sent_micros  = cap_sus;
    snap_d.rcv_seconds  = pkt_i.receive_seconds;
    snap_d.rcv_micros   = pkt_i.receive_micros;
  end

  // Advance on a transfer; drop all packet state after the last byte.
  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    proto_d = proto_q;
    ttl_d   = ttl_q;
    type_d  = type_q;
    code_d  = code_q;
    id_d    = id_q;
    seq_d   = seq_q;
    ssec_d  = ssec_q;
    sus_d   = sus_q;
    if (accept && last) begin
      pos_d   = '0;
      hdr_d   = '0;
      proto_d = '0;
      ttl_d   = '0;
      type_d  = '0;
      code_d  = '0;
      id_d    = '0;
      seq_d   = '0;
      ssec_d  = '0;
      sus_d   = '0;
    end else if (accept) begin
      pos_d   = cap_pos;
      hdr_d   = cap_hdr;
      proto_d = cap_proto;
      ttl_d   = cap_ttl;
      type_d  = cap_type;
      code_d  = cap_code;
      id_d    = cap_id;
      seq_d   = cap_seq;
      ssec_d  = cap_ssec;
      sus_d   = cap_sus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      hdr_q        <= '0;
      proto_q      <= '0;
      ttl_q        <= '0;
      type_q       <= '0;
      code_q       <= '0;
      id_q         <= '0;
      seq_q        <= '0;
      ssec_q       <= '0;
      sus_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      proto_q <= proto_d;
      ttl_q   <= ttl_d;
      type_q  <= type_d;
      code_q  <= code_d;
      id_q    <= id_d;
      seq_q   <= seq_d;
      ssec_q  <= ssec_d;
      sus_q   <= sus_d;
      if (accept && last) begin
        snap_valid_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      snap_q <= snap_d;
    end
  end

  `ICMP_ERP_ASSERT_NEXT(a_last_fills_snap, clk_i, rst_ni, accept && last,
                        snap_valid_q, "last byte did not fill snapshot")
  `ICMP_ERP_ASSERT_NEXT(a_last_clears_pos, clk_i, rst_ni, accept && last,
                        pos_q == '0, "byte count not cleared after last byte")
  `ICMP_ERP_ASSERT_IMPLIES(a_pos_bound, clk_i, rst_ni, 1'b1,
                           pos_q <= PosW'(MaxPacketBytes), "byte count past maximum")

endmodule

FILE: hw/rtl/icmp_erp_classify.sv
`include "icmp_echo_reply_parser_assert.svh"

module icmp_erp_classify (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [15:0]             own_identifier_i,
  input  logic                    report_other_types_i,
  input  logic                    snap_valid_i,
  input  icmp_erp_pkg::pkt_snap_t snap_i,
  output logic                    snap_ready_o,
  icmp_erp_out_if.source          res_o
);

  localparam logic [33:0] UsPerSec = 34'(icmp_erp_pkg::MICROS_PER_SECOND);
  localparam logic [33:0] UsMax    = 34'(icmp_erp_pkg::MICROS_PER_SECOND - 1);

  logic                  valid_q;
  icmp_erp_pkg::status_e status_d, status_q;
  logic [31:0]           tsec_d, tsec_q;
  logic [19:0]           tus_d, tus_q;
  logic [11:0]           len_q;
  logic [15:0]           seq_q, id_q;
  logic [7:0]            ttl_q, type_q, code_q;

  logic [33:0] us_diff, us_adj;
  logic        borrow;
  logic [19:0] us_clamped;
  logic [31:0] sec_diff;
  logic        take;

  assign snap_ready_o = ~valid_q | res_o.ready;
  assign take         = snap_valid_i & snap_ready_o;

  // Round trip: a single borrow from the seconds, then clamp the microseconds.
  assign us_diff  = {14'd0, snap_i.rcv_micros} - {2'b00, snap_i.sent_micros};
  assign borrow   = us_diff[33];
  assign us_adj   = borrow ? us_diff + UsPerSec : us_diff;
  assign sec_diff = snap_i.rcv_seconds - {31'd0, borrow} - snap_i.sent_seconds;

  always_comb begin
    if (us_adj[33]) begin
      us_clamped = '0;
    end else if (us_adj > UsMax) begin
      us_clamped = UsMax[19:0];
    end else begin
      us_clamped = us_adj[19:0];
    end
  end

  always_comb begin
    tsec_d = '0;
    tus_d  = '0;
    if (snap_i.protocol != icmp_erp_pkg::PROTO_ICMP) begin
      status_d = icmp_erp_pkg::ST_NOT_ICMP;
    end else if (snap_i.len_short) begin
      status_d = icmp_erp_pkg::ST_TOO_SHORT;
    end else if (snap_i.msg_type == icmp_erp_pkg::TYPE_ECHO_REPLY) begin
      if (snap_i.identifier != own_identifier_i) begin
        status_d = icmp_erp_pkg::ST_WRONG_ID;
      end else if (snap_i.reply_short) begin
        status_d = icmp_erp_pkg::ST_REPLY_SHORT;
      end else begin
        status_d = icmp_erp_pkg::ST_REPLY_OK;
        tsec_d   = sec_diff;
        tus_d    = us_clamped;
      end
    end else if (report_other_types_i) begin
      status_d = icmp_erp_pkg::ST_OTHER_TYPE;
    end else begin
      status_d = icmp_erp_pkg::ST_IGNORED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      tsec_q   <= tsec_d;
      tus_q    <= tus_d;
      len_q    <= snap_i.icmp_length;
      seq_q    <= snap_i.seq_num;
      id_q     <= snap_i.identifier;
      ttl_q    <= snap_i.ttl;
      type_q   <= snap_i.msg_type;
      code_q   <= snap_i.msg_code;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.status          = status_q;
  assign res_o.icmp_length     = len_q;
  assign res_o.sequence_number = seq_q;
  assign res_o.time_to_live    = ttl_q;
  assign res_o.message_type    = type_q;
  assign res_o.message_code    = code_q;
  assign res_o.seen_identifier = id_q;
  assign res_o.trip_seconds    = $signed(tsec_q);
  assign res_o.trip_micros     = tus_q;

  `ICMP_ERP_ASSERT_IMPLIES(a_trip_zero, clk_i, rst_ni, valid_q && (status_q != icmp_erp_pkg::ST_REPLY_OK), (tsec_q == '0) && (tus_q == '0), "trip time set on a non-reply result")
  `ICMP_ERP_ASSERT_IMPLIES(a_micros_range, clk_i, rst_ni, valid_q, tus_q <= UsMax[19:0], "trip microseconds out of range")

endmodule

FILE: hw/rtl/icmp_echo_reply_parser.sv
// Channel   | Dir | Transfer moves                         | Rate
// pkt_i     | in  | one packet byte, last flag, rx time    | one byte per cycle while ready
// res_o     | out | one status with captured fields, trip  | one per packet
// APB       | in  | own identifier, report-other-types     | write, no wait states
//
// A byte is taken every cycle while the snapshot stage can move on.
// After the transfer of the last byte the result passes through the packet
// snapshot register and then the result register.
// Reset (rst_ni low) clears byte count, captured fields, config registers, valids.
// A stalled result holds; a second finished packet waits in the snapshot
// stage, and only then does pkt_i.ready drop.
module icmp_echo_reply_parser #(
  parameter int MaxPacketBytes = icmp_erp_pkg::MAX_PACKET_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  icmp_erp_in_if.sink                         pkt_i,
  icmp_erp_out_if.source                      res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [icmp_erp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0] own_id_q;
  logic        report_q;
  logic        cfg_wr;

  logic                    snap_valid;
  logic                    snap_ready;
  icmp_erp_pkg::pkt_snap_t snap;

  icmp_erp_pkg::reg_idx_e reg_idx;

  // Register file: byte addresses, the index is address bit 2, the word number.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = icmp_erp_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      report_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        icmp_erp_pkg::REG_OWN_IDENTIFIER: own_id_q <= pwdata[15:0];
        icmp_erp_pkg::REG_REPORT_OTHER:   report_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      icmp_erp_pkg::REG_OWN_IDENTIFIER: prdata = {16'd0, own_id_q};
      icmp_erp_pkg::REG_REPORT_OTHER:   prdata = {31'd0, report_q};
      default:                          prdata = '0;
    endcase
  end

  // Byte capture: counts the packet, picks fields at fixed offsets and
  // hands a snapshot on at the last byte.
  icmp_erp_capture #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_i),
    .snap_ready_i(snap_ready),
    .snap_valid_o(snap_valid),
    .snap_o      (snap)
  );

  // Classification and round-trip arithmetic into the result register.
  icmp_erp_classify u_classify (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .own_identifier_i    (own_id_q),
    .report_other_types_i(report_q),
    .snap_valid_i        (snap_valid),
    .snap_i              (snap),
    .snap_ready_o        (snap_ready),
    .res_o               (res_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int         MAX_PACKET_BYTES  = icmp_erp_pkg::MAX_PACKET_BYTES;
  localparam int         MICROS_PER_SECOND = icmp_erp_pkg::MICROS_PER_SECOND;
  localparam int         ICMP_MIN_BYTES    = icmp_erp_pkg::ICMP_MIN_BYTES;
  localparam int         REPLY_MIN_BYTES   = icmp_erp_pkg::REPLY_MIN_BYTES;
  localparam int         APB_ADDR_W        = icmp_erp_pkg::APB_ADDR_W;
  localparam logic [7:0] PROTO_ICMP        = icmp_erp_pkg::PROTO_ICMP;
  localparam logic [7:0] TYPE_ECHO_REPLY   = icmp_erp_pkg::TYPE_ECHO_REPLY;

  // Cycle ceiling for the whole run: about a thousand bytes, even with every
  // byte waiting out the longest sender gap, finish far below this.
  localparam int CYCLE_LIMIT = 400000;

  // One byte of a received packet as the sender offers it.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [31:0] rx_sec;
    logic [19:0] rx_us;
  } pkt_byte_t;

  // One classification result as the parser should report it.
  typedef struct {
    icmp_erp_pkg::status_e status;
    logic [11:0]           icmp_len;
    logic [15:0]           seq;
    logic [7:0]            ttl;
    logic [7:0]            mtype;
    logic [7:0]            mcode;
    logic [15:0]           ident;
    logic signed [31:0]    trip_sec;
    logic [19:0]           trip_us;
  } echo_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Register port, idle from time zero.
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  icmp_erp_in_if  pkt_if ();
  icmp_erp_out_if res_if ();

  icmp_echo_reply_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pkt_i   (pkt_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bytes waiting to be offered, and results the parser still owes us.
  pkt_byte_t    pending_bytes[$];
  echo_result_t expected_results[$];
  pkt_byte_t    cur_byte;
  echo_result_t oldest_result;

  int bytes_queued = 0;
  int pkts_queued  = 0;
  int bytes_taken  = 0;
  int mismatches   = 0;
  int cycles       = 0;

  int send_idle   = 0;
  int recv_stall  = 0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;
  logic hold_off  = 1'b0;

  // Shadow copy of the parser's registers.
  logic [15:0] cfg_own_id       = '0;
  logic        cfg_report_other = 1'b0;

  // Shadow copy of the per-packet capture state.
  int          pkt_pos;
  int          ip_hdr_len;
  logic [7:0]  proto_q;
  logic [7:0]  ttl_q;
  logic [7:0]  type_q;
  logic [7:0]  code_q;
  logic [15:0] ident_q;
  logic [15:0] seq_q;
  logic [31:0] tx_sec_q;
  logic [31:0] tx_us_q;

  // Clock and the single reset pulse.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    pkt_if.valid           = 1'b0;
    pkt_if.data_byte       = '0;
    pkt_if.last_byte       = 1'b0;
    pkt_if.receive_seconds = '0;
    pkt_if.receive_micros  = '0;
    res_if.ready           = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap length for either side: mostly none, some short, a few long. A side in
  // calm mode never idles, which gives back-to-back stretches.
  function automatic int gap_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_capture();
    pkt_pos    = 0;
    ip_hdr_len = 0;
    proto_q    = '0;
    ttl_q      = '0;
    type_q     = '0;
    code_q     = '0;
    ident_q    = '0;
    seq_q      = '0;
    tx_sec_q   = '0;
    tx_us_q    = '0;
  endtask

  // Advance the capture state by one accepted byte; on the last byte of a
  // packet, push the classification it must produce and clear the state.
  task automatic parse_byte(input pkt_byte_t it);
    int           k;
    int           total;
    int           icmp_len;
    longint       usec_diff;
    logic [31:0]  sec_left;
    echo_result_t res;
    if (pkt_pos < MAX_PACKET_BYTES) begin
      if (pkt_pos == 0) ip_hdr_len = int'(it.data[3:0]) * 4;
      if (pkt_pos == 8) ttl_q = it.data;
      if (pkt_pos == 9) proto_q = it.data;
      if (pkt_pos >= ip_hdr_len) begin
        // ICMP offsets count from the header length even when it is bogus.
        k = pkt_pos - ip_hdr_len;
        if (k == 0) type_q = it.data;
        else if (k == 1) code_q = it.data;
        else if (k == 4) ident_q[7:0] = it.data;
        else if (k == 5) ident_q[15:8] = it.data;
        else if (k == 6) seq_q[7:0] = it.data;
        else if (k == 7) seq_q[15:8] = it.data;
        else if (k >= 8 && k <= 11) tx_sec_q[8*(k-8) +: 8] = it.data;
        else if (k >= 12 && k <= 15) tx_us_q[8*(k-12) +: 8] = it.data;
      end
      pkt_pos++;
    end
    if (!it.last) return;

    total    = pkt_pos;
    icmp_len = (total >= ip_hdr_len) ? total - ip_hdr_len : 0;
    res.trip_sec = '0;
    res.trip_us  = '0;
    if (proto_q != PROTO_ICMP) begin
      res.status = icmp_erp_pkg::ST_NOT_ICMP;
    end else if (total < ip_hdr_len || icmp_len < ICMP_MIN_BYTES) begin
      res.status = icmp_erp_pkg::ST_TOO_SHORT;
    end else if (type_q == TYPE_ECHO_REPLY) begin
      if (ident_q != cfg_own_id) begin
        res.status = icmp_erp_pkg::ST_WRONG_ID;
      end else if (icmp_len < REPLY_MIN_BYTES) begin
        res.status = icmp_erp_pkg::ST_REPLY_SHORT;
      end else begin
        // Single borrow from the seconds, then clamp the microseconds.
        usec_diff = longint'(it.rx_us) - longint'(tx_us_q);
        sec_left  = it.rx_sec;
        if (usec_diff < 0) begin
          sec_left  = sec_left - 32'd1;
          usec_diff = usec_diff + MICROS_PER_SECOND;
        end
        if (usec_diff < 0) usec_diff = 0;
        if (usec_diff > MICROS_PER_SECOND - 1) usec_diff = MICROS_PER_SECOND - 1;
        res.trip_us  = 20'(usec_diff);
        res.trip_sec = sec_left - tx_sec_q;
        res.status   = icmp_erp_pkg::ST_REPLY_OK;
      end
    end else begin
      res.status = cfg_report_other ? icmp_erp_pkg::ST_OTHER_TYPE : icmp_erp_pkg::ST_IGNORED;
    end
    res.icmp_len = 12'(icmp_len);
    res.seq      = seq_q;
    res.ttl      = ttl_q;
    res.mtype    = type_q;
    res.mcode    = code_q;
    res.ident    = ident_q;
    expected_results.push_back(res);
    clear_capture();
  endtask

  // Sender: offer the next pending byte, hold it until the transfer, and put
  // random gaps between bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_if.valid <= 1'b0;
      send_idle = 0;
      clear_capture();
    end else begin
      if (pkt_if.valid && pkt_if.ready) begin
        parse_byte(cur_byte);
        bytes_taken++;
      end
      if (!pkt_if.valid || pkt_if.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          pkt_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          cur_byte = pending_bytes.pop_front();
          pkt_if.valid           <= 1'b1;
          pkt_if.data_byte       <= cur_byte.data;
          pkt_if.last_byte       <= cur_byte.last;
          pkt_if.receive_seconds <= cur_byte.rx_sec;
          pkt_if.receive_micros  <= cur_byte.rx_us;
          if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
          send_idle = gap_len(send_calm);
        end else begin
          pkt_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: check every result transfer against the oldest expectation and
  // stall at random, or for a long stretch while hold_off is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected, status %0d", res_if.status);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("status", 32'(oldest_result.status), 32'(res_if.status));
          check_field("icmp_length", 32'(oldest_result.icmp_len), 32'(res_if.icmp_length));
          check_field("sequence_number", 32'(oldest_result.seq),
                      32'(res_if.sequence_number));
          check_field("time_to_live", 32'(oldest_result.ttl), 32'(res_if.time_to_live));
          check_field("message_type", 32'(oldest_result.mtype), 32'(res_if.message_type));
          check_field("message_code", 32'(oldest_result.mcode), 32'(res_if.message_code));
          check_field("seen_identifier", 32'(oldest_result.ident),
                      32'(res_if.seen_identifier));
          check_field("trip_seconds", oldest_result.trip_sec, res_if.trip_seconds);
          check_field("trip_micros", 32'(oldest_result.trip_us), 32'(res_if.trip_micros));
        end
      end
      if (hold_off) begin
        res_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
        recv_stall = gap_len(recv_calm);
      end
    end
  end

  // Long receiver hold-off once traffic is flowing: the parser must buffer
  // two finished packets and then stall its byte input.
  initial begin
    wait (bytes_taken >= 500);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Register write with setup and access phases; the register takes the value at the access edge.
  task automatic reg_write(input icmp_erp_pkg::reg_idx_e idx, input logic [31:0] val);
    logic [APB_ADDR_W-1:0] addr;
    addr = idx;
    addr = addr << 2;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == icmp_erp_pkg::REG_OWN_IDENTIFIER) cfg_own_id = val[15:0];
    else cfg_report_other = val[0];
  endtask

  // Upper bits of the write data are junk the parser must drop.
  task automatic set_config(input logic [15:0] own_id, input logic report_other);
    reg_write(icmp_erp_pkg::REG_OWN_IDENTIFIER, {16'($urandom), own_id});
    reg_write(icmp_erp_pkg::REG_REPORT_OTHER, {31'($urandom), report_other});
  endtask

  // Wait until every byte is taken and every result has come back, then let
  // the two-stage pipeline settle.
  task automatic drain();
    while (bytes_taken != bytes_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Queue a packet; the receive time rides with the last byte, other bytes
  // carry random time values the parser must ignore.
  task automatic queue_bytes(input logic [7:0] pkt[$], input logic [31:0] rx_sec,
                             input logic [19:0] rx_us);
    pkt_byte_t it;
    foreach (pkt[i]) begin
      it.data   = pkt[i];
      it.last   = (i == pkt.size() - 1);
      it.rx_sec = it.last ? rx_sec : $urandom;
      it.rx_us  = it.last ? rx_us : 20'($urandom_range(0, 999999));
      pending_bytes.push_back(it);
      bytes_queued++;
    end
    pkts_queued++;
  endtask

  // Build an IPv4 packet with an ICMP echo-style header. A nonzero cut
  // truncates the packet to that many bytes; every packet has at least one.
  task automatic queue_echo(input int ihl, input logic [7:0] proto, input logic [7:0] mtype,
                            input logic [15:0] ident, input int icmp_bytes, input int cut,
                            input logic [31:0] tx_sec, input logic [31:0] tx_us,
                            input logic [31:0] rx_sec, input logic [19:0] rx_us);
    logic [7:0] pkt[$];
    logic [7:0] icmp_hdr[16];
    int         hl;
    int         total;
    int         idx;
    hl    = ihl * 4;
    total = hl + icmp_bytes;
    if (cut > 0 && cut < total) total = cut;
    if (total < 1) total = 1;
    for (int i = 0; i < total; i++) pkt.push_back(8'($urandom));
    pkt[0] = {4'h4, 4'(ihl)};
    if (total > 9) pkt[9] = proto;
    foreach (icmp_hdr[k]) icmp_hdr[k] = 8'($urandom);
    icmp_hdr[0] = mtype;
    icmp_hdr[4] = ident[7:0];
    icmp_hdr[5] = ident[15:8];
    for (int k = 0; k < 4; k++) begin
      icmp_hdr[8 + k]  = tx_sec[8*k +: 8];
      icmp_hdr[12 + k] = tx_us[8*k +: 8];
    end
    // With a short header the ICMP fields land on top of IP header bytes;
    // keep the length byte so the header length stays as chosen.
    for (int k = 0; k < 16; k++) begin
      idx = hl + k;
      if (idx < total && idx != 0) pkt[idx] = icmp_hdr[k];
    end
    queue_bytes(pkt, rx_sec, rx_us);
  endtask

  // Random traffic: nearly half well-formed replies with random content, the rest
  // every other classification, odd header lengths, truncation and noise.
  task automatic queue_random_packets(input int min_bytes, input int min_pkts);
    int          start_bytes;
    int          start_pkts;
    int          r;
    int          len;
    logic [7:0]  proto;
    logic [7:0]  mtype;
    logic [31:0] rxs;
    logic [19:0] rxu;
    logic [31:0] txs;
    logic [31:0] txu;
    logic [7:0]  noise[$];
    start_bytes = bytes_queued;
    start_pkts  = pkts_queued;
    while (bytes_queued - start_bytes < min_bytes || pkts_queued - start_pkts < min_pkts) begin
      r   = $urandom_range(0, 99);
      rxs = $urandom;
      rxu = 20'($urandom_range(0, 999999));
      txs = ($urandom_range(0, 3) == 0) ? $urandom : rxs - $urandom_range(0, 5);
      case ($urandom_range(0, 5))
        0: txu = $urandom;
        1: txu = 32'd0;
        2: txu = MICROS_PER_SECOND - 1;
        default: txu = $urandom_range(0, 999999);
      endcase
      if (r < 45) begin
        queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, cfg_own_id, $urandom_range(16, 20), 0,
                   txs, txu, rxs, rxu);
      end else if (r < 54) begin
        queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, cfg_own_id ^ (16'd1 << $urandom_range(0, 15)),
                   $urandom_range(16, 20), 0, txs, txu, rxs, rxu);
      end else if (r < 62) begin
        queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, cfg_own_id, $urandom_range(8, 15), 0,
                   txs, txu, rxs, rxu);
      end else if (r < 71) begin
        mtype = 8'($urandom_range(1, 255));
        queue_echo(5, PROTO_ICMP, mtype, 16'($urandom), $urandom_range(8, 20), 0,
                   txs, txu, rxs, rxu);
      end else if (r < 78) begin
        proto = 8'($urandom);
        if (proto == PROTO_ICMP) proto = 8'd6;
        queue_echo(5, proto, TYPE_ECHO_REPLY, cfg_own_id, $urandom_range(8, 20), 0,
                   txs, txu, rxs, rxu);
      end else if (r < 84) begin
        queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, cfg_own_id, $urandom_range(0, 7), 0,
                   txs, txu, rxs, rxu);
      end else if (r < 90) begin
        mtype = $urandom_range(0, 1) ? TYPE_ECHO_REPLY : 8'($urandom);
        queue_echo($urandom_range(0, 15), PROTO_ICMP, mtype, cfg_own_id,
                   $urandom_range(0, 24), 0, txs, txu, rxs, rxu);
      end else if (r < 96) begin
        noise.delete();
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) noise.push_back(8'($urandom));
        queue_bytes(noise, rxs, rxu);
      end else begin
        queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, cfg_own_id, 16, $urandom_range(1, 36),
                   txs, txu, rxs, rxu);
      end
    end
  endtask

  // Main sequence: configure, directed packets, then random phases under
  // different register settings, each phase drained before the next write.
  initial begin
    @(posedge rst_ni);

    set_config(16'h0000, 1'b0);
    // A one-byte packet and one that ends before the protocol byte: not ICMP.
    queue_bytes('{8'h45}, 32'hFFFF_FFFF, 20'd999999);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 9, 0, 0, 0, 0);
    // Header longer than the packet, then an ICMP part under eight bytes.
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 14, 0, 0, 0, 0);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 7, 0, 0, 0, 0, 0);
    queue_echo(5, 8'd17, TYPE_ECHO_REPLY, 16'h0000, 16, 0, 0, 0, 0, 0);
    // Accepted replies: no borrow, borrow with seconds wrap, clamped micros.
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 0, 32'd0, 32'd0,
               32'hFFFF_FFFF, 20'd999999);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 24, 0, 32'hFFFF_FFFF, 32'd999999,
               32'd0, 20'd0);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 0, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h7FFF_FFFF, 20'd500000);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'hFFFF, 16, 0, 0, 0, 0, 0);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 8, 0, 0, 0, 0, 0);
    queue_echo(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 15, 0, 0, 0, 0, 0);
    // Other types while they are ignored.
    queue_echo(5, PROTO_ICMP, 8'd8, 16'h0000, 16, 0, 0, 0, 0, 0);
    queue_echo(5, PROTO_ICMP, 8'd255, 16'h0000, 8, 0, 0, 0, 0, 0);
    // Odd header lengths: zero overlaps the type with the first byte.
    queue_echo(0, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 20, 0, 0, 0, 1, 1);
    queue_echo(2, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 0, 0, 0, 1, 1);
    queue_echo(15, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 16, 0, 5, 7, 9, 3);
    drain();

    set_config(16'hFFFF, 1'b1);
    queue_random_packets(175, 4);
    drain();

    set_config(16'($urandom), 1'b0);
    queue_random_packets(175, 4);
    drain();

    set_config(16'($urandom), 1'b1);
    queue_random_packets(175, 4);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
